// File: rtl/pgr_pkg.sv
package pgr_pkg;

	localparam int MAX_V    = 64;
	localparam int IDX_W    = $clog2(MAX_V);
	localparam int CNT_W    = IDX_W + 1;
	localparam int FRAC_W   = 30;
	localparam int RANK_W   = FRAC_W + 2;
	localparam int DAMP_W   = 17;
	localparam int THR_W    = 32;
	localparam int ITER_W   = 16;
	localparam int DIFF_W   = RANK_W + IDX_W + 1;
	localparam int QUO_W    = RANK_W + 1;
	localparam int ROW_W    = MAX_V + CNT_W;
	localparam int OP_W     = 5;

	localparam logic [DAMP_W-1:0] DAMP_ONE = 17'd65536;
	localparam logic [CNT_W-1:0]  N_MAX    = CNT_W'(MAX_V);

	localparam logic [1:0] ACT_ADD     = 2'd0;
	localparam logic [1:0] ACT_CLEAR   = 2'd1;
	localparam logic [1:0] ACT_COMPUTE = 2'd2;

	localparam logic [1:0] REG_DAMP  = 2'd0;
	localparam logic [1:0] REG_THR   = 2'd1;
	localparam logic [1:0] REG_ITER  = 2'd2;
	localparam logic [1:0] REG_COUNT = 2'd3;

	localparam logic [OP_W-1:0] OP_NONE     = 5'd0;
	localparam logic [OP_W-1:0] OP_LOAD     = 5'd1;
	localparam logic [OP_W-1:0] OP_CLEAR    = 5'd2;
	localparam logic [OP_W-1:0] OP_ADD_RD   = 5'd3;
	localparam logic [OP_W-1:0] OP_ADD_WR   = 5'd4;
	localparam logic [OP_W-1:0] OP_DIV_ONE  = 5'd5;
	localparam logic [OP_W-1:0] OP_CAP_ONE  = 5'd6;
	localparam logic [OP_W-1:0] OP_DIV_BASE = 5'd7;
	localparam logic [OP_W-1:0] OP_CAP_BASE = 5'd8;
	localparam logic [OP_W-1:0] OP_INIT_WR  = 5'd9;
	localparam logic [OP_W-1:0] OP_CHECK    = 5'd10;
	localparam logic [OP_W-1:0] OP_CT_RD    = 5'd11;
	localparam logic [OP_W-1:0] OP_CT_MUL   = 5'd12;
	localparam logic [OP_W-1:0] OP_CT_GO    = 5'd13;
	localparam logic [OP_W-1:0] OP_CT_WR    = 5'd14;
	localparam logic [OP_W-1:0] OP_AC_RD    = 5'd15;
	localparam logic [OP_W-1:0] OP_AC_ADD   = 5'd16;
	localparam logic [OP_W-1:0] OP_AC_OLD   = 5'd17;
	localparam logic [OP_W-1:0] OP_AC_WR    = 5'd18;
	localparam logic [OP_W-1:0] OP_OUT_RD   = 5'd19;
	localparam logic [OP_W-1:0] OP_OUT      = 5'd20;

	typedef struct packed {
		logic [DAMP_W-1:0] damp;
		logic [THR_W-1:0]  thr;
		logic [ITER_W-1:0] max_iter;
		logic [CNT_W-1:0]  n;
	} cfg_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            i_clr;
		logic            i_inc;
		logic            j_clr;
		logic            j_inc;
	} cmd_t;

	typedef struct packed {
		logic div_busy;
		logic i_last;
		logic j_last;
		logic go_on;
	} stat_t;

endpackage

// File: rtl/pgr_divider.sv
module pgr_divider
	import pgr_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [QUO_W-1:0] num,
	input  logic [CNT_W-1:0] den,
	output logic             busy,
	output logic [QUO_W-1:0] quo
);

	localparam int STEP_W = $clog2(QUO_W + 1);

	logic [STEP_W-1:0] step_q;
	logic [QUO_W-1:0]  quo_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  den_q;
	logic [CNT_W:0]    trial;

	assign trial = {rem_q, quo_q[QUO_W-1]};
	assign busy  = (step_q != '0);
	assign quo   = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (start) begin
			step_q <= STEP_W'(QUO_W);
		end else if (busy) begin
			step_q <= step_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy) begin
			if (trial >= {1'b0, den_q}) begin
				rem_q <= CNT_W'(trial - {1'b0, den_q});
				quo_q <= {quo_q[QUO_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[CNT_W-1:0];
				quo_q <= {quo_q[QUO_W-2:0], 1'b0};
			end
		end
	end

endmodule

// File: rtl/pgr_ctrl.sv
module pgr_ctrl
	import pgr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] action,
	input  stat_t      stat,
	output cmd_t       cmd,
	output logic       busy,
	output logic       result_valid
);

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_ADD_RD = 5'd1;
	localparam logic [4:0] S_ADD_WR = 5'd2;
	localparam logic [4:0] S_GO1    = 5'd3;
	localparam logic [4:0] S_W1     = 5'd4;
	localparam logic [4:0] S_GO2    = 5'd5;
	localparam logic [4:0] S_W2     = 5'd6;
	localparam logic [4:0] S_INIT   = 5'd7;
	localparam logic [4:0] S_CHECK  = 5'd8;
	localparam logic [4:0] S_CT_RD  = 5'd9;
	localparam logic [4:0] S_CT_MUL = 5'd10;
	localparam logic [4:0] S_CT_GO  = 5'd11;
	localparam logic [4:0] S_CT_W   = 5'd12;
	localparam logic [4:0] S_AC_RD  = 5'd13;
	localparam logic [4:0] S_AC_ADD = 5'd14;
	localparam logic [4:0] S_AC_OLD = 5'd15;
	localparam logic [4:0] S_AC_WR  = 5'd16;
	localparam logic [4:0] S_OUT_RD = 5'd17;
	localparam logic [4:0] S_OUT    = 5'd18;

	logic [4:0] state_q;
	logic [4:0] state_d;

	assign busy         = (state_q != S_IDLE);
	assign result_valid = (state_q == S_OUT);

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		cmd.op    = OP_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					unique case (action)
						ACT_ADD: begin
							cmd.op  = OP_LOAD;
							state_d = S_ADD_RD;
						end
						ACT_CLEAR: cmd.op = OP_CLEAR;
						ACT_COMPUTE: state_d = S_GO1;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_ADD_RD: begin
				cmd.op  = OP_ADD_RD;
				state_d = S_ADD_WR;
			end
			S_ADD_WR: begin
				cmd.op  = OP_ADD_WR;
				state_d = S_IDLE;
			end
			S_GO1: begin
				cmd.op  = OP_DIV_ONE;
				state_d = S_W1;
			end
			S_W1: begin
				if (!stat.div_busy) begin
					cmd.op  = OP_CAP_ONE;
					state_d = S_GO2;
				end
			end
			S_GO2: begin
				cmd.op  = OP_DIV_BASE;
				state_d = S_W2;
			end
			S_W2: begin
				if (!stat.div_busy) begin
					cmd.op    = OP_CAP_BASE;
					cmd.i_clr = 1'b1;
					state_d   = S_INIT;
				end
			end
			S_INIT: begin
				cmd.op = OP_INIT_WR;
				if (stat.i_last) begin
					state_d = S_CHECK;
				end else begin
					cmd.i_inc = 1'b1;
				end
			end
			S_CHECK: begin
				cmd.op    = OP_CHECK;
				cmd.i_clr = 1'b1;
				cmd.j_clr = 1'b1;
				state_d   = stat.go_on ? S_CT_RD : S_OUT_RD;
			end
			S_CT_RD: begin
				cmd.op  = OP_CT_RD;
				state_d = S_CT_MUL;
			end
			S_CT_MUL: begin
				cmd.op  = OP_CT_MUL;
				state_d = S_CT_GO;
			end
			S_CT_GO: begin
				cmd.op  = OP_CT_GO;
				state_d = S_CT_W;
			end
			S_CT_W: begin
				if (!stat.div_busy) begin
					cmd.op = OP_CT_WR;
					if (stat.j_last) begin
						cmd.j_clr = 1'b1;
						cmd.i_clr = 1'b1;
						state_d   = S_AC_RD;
					end else begin
						cmd.j_inc = 1'b1;
						state_d   = S_CT_RD;
					end
				end
			end
			S_AC_RD: begin
				cmd.op  = OP_AC_RD;
				state_d = S_AC_ADD;
			end
			S_AC_ADD: begin
				cmd.op = OP_AC_ADD;
				if (stat.j_last) begin
					state_d = S_AC_OLD;
				end else begin
					cmd.j_inc = 1'b1;
					state_d   = S_AC_RD;
				end
			end
			S_AC_OLD: begin
				cmd.op  = OP_AC_OLD;
				state_d = S_AC_WR;
			end
			S_AC_WR: begin
				cmd.op    = OP_AC_WR;
				cmd.j_clr = 1'b1;
				if (stat.i_last) begin
					state_d = S_CHECK;
				end else begin
					cmd.i_inc = 1'b1;
					state_d   = S_AC_RD;
				end
			end
			S_OUT_RD: begin
				cmd.op  = OP_OUT_RD;
				state_d = S_OUT;
			end
			S_OUT: begin
				cmd.op = OP_OUT;
				if (stat.i_last) begin
					state_d = S_IDLE;
				end else begin
					cmd.i_inc = 1'b1;
					state_d   = S_OUT_RD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: rtl/pgr_datapath.sv
module pgr_datapath
	import pgr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	input  cfg_t              cfg,
	input  logic [IDX_W-1:0]  edge_source,
	input  logic [IDX_W-1:0]  edge_target,
	output stat_t             stat,
	output logic [IDX_W-1:0]  vertex_index,
	output logic [RANK_W-1:0] rank_value,
	output logic [ITER_W-1:0] iterations_run,
	output logic              last_result
);

	logic [ROW_W-1:0]  row_mem [MAX_V];
	logic [MAX_V-1:0]  row_valid_q;
	logic [ROW_W-1:0]  row_rd_q;
	logic              row_vld_q;
	logic [RANK_W-1:0] rank_mem [2*MAX_V];
	logic [RANK_W-1:0] rd_q;
	logic [QUO_W-1:0]  ctb_mem [MAX_V];
	logic [QUO_W-1:0]  ctb_q;

	logic [IDX_W-1:0]  src_q, dst_q, i_q, j_q;
	logic [RANK_W-1:0] init_q, base_q, acc_q;
	logic [QUO_W-1:0]  prod_q;
	logic [CNT_W-1:0]  deg_q;
	logic [DIFF_W-1:0] diff_q;
	logic [ITER_W-1:0] iter_q;
	logic              bank_q;

	logic [MAX_V-1:0]  row_bits, new_bits;
	logic [CNT_W-1:0]  row_deg;
	logic [IDX_W-1:0]  row_ra;
	logic              row_we;
	logic [IDX_W:0]    rank_ra, rank_wa;
	logic              rank_we;
	logic [RANK_W-1:0] rank_wd;
	logic [DAMP_W+RANK_W-1:0] mult;
	logic [RANK_W+1:0] sum;
	logic [RANK_W-1:0] absdiff;
	logic [IDX_W-1:0]  n_last;
	logic              div_start, div_busy;
	logic [QUO_W-1:0]  div_num, div_quo;
	logic [CNT_W-1:0]  div_den;
	logic [DAMP_W-1:0] one_minus_d;

	assign row_bits = row_vld_q ? row_rd_q[MAX_V-1:0] : '0;
	assign row_deg  = row_vld_q ? row_rd_q[ROW_W-1:MAX_V] : '0;
	assign n_last   = IDX_W'(cfg.n - 1'b1);

	always_comb begin
		new_bits              = row_bits;
		new_bits[dst_q]       = 1'b1;
	end

	assign row_ra = (cmd.op == OP_ADD_RD) ? src_q : j_q;
	assign row_we = (cmd.op == OP_ADD_WR) && !row_bits[dst_q];

	always_ff @(posedge clk) begin
		if (row_we) begin
			row_mem[src_q] <= {CNT_W'(row_deg + 1'b1), new_bits};
		end
		row_rd_q  <= row_mem[row_ra];
		row_vld_q <= row_valid_q[row_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
		end else if (cmd.op == OP_CLEAR) begin
			row_valid_q <= '0;
		end else if (row_we) begin
			row_valid_q[src_q] <= 1'b1;
		end
	end

	always_comb begin
		rank_ra = {bank_q, i_q};
		if (cmd.op == OP_CT_RD) begin
			rank_ra = {bank_q, j_q};
		end
		rank_we = (cmd.op == OP_INIT_WR) || (cmd.op == OP_AC_WR);
		rank_wa = (cmd.op == OP_INIT_WR) ? {bank_q, i_q} : {~bank_q, i_q};
		rank_wd = (cmd.op == OP_INIT_WR) ? init_q : acc_q;
	end

	always_ff @(posedge clk) begin
		if (rank_we) begin
			rank_mem[rank_wa] <= rank_wd;
		end
		rd_q <= rank_mem[rank_ra];
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_CT_WR) begin
			ctb_mem[j_q] <= (deg_q == '0) ? '0 : div_quo;
		end
		ctb_q <= ctb_mem[j_q];
	end

	assign one_minus_d = DAMP_ONE - cfg.damp;

	always_comb begin
		div_start = 1'b0;
		div_num   = prod_q;
		div_den   = cfg.n;
		case (cmd.op)
			OP_DIV_ONE: begin
				div_start = 1'b1;
				div_num   = QUO_W'(1) << FRAC_W;
			end
			OP_DIV_BASE: begin
				div_start = 1'b1;
				div_num   = QUO_W'({one_minus_d, {(FRAC_W-16){1'b0}}});
			end
			OP_CT_GO: begin
				div_start = 1'b1;
				div_den   = deg_q;
			end
			default: div_start = 1'b0;
		endcase
	end

	pgr_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.quo    (div_quo)
	);

	assign mult    = rd_q * cfg.damp;
	assign sum     = {2'b00, acc_q} + {1'b0, ctb_q};
	assign absdiff = (acc_q >= rd_q) ? (acc_q - rd_q) : (rd_q - acc_q);

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				src_q <= edge_source;
				dst_q <= edge_target;
			end
			OP_DIV_ONE: begin
				iter_q <= '0;
				diff_q <= DIFF_W'(cfg.thr);
				bank_q <= 1'b0;
			end
			OP_CAP_ONE:  init_q <= div_quo[RANK_W-1:0];
			OP_CAP_BASE: base_q <= div_quo[RANK_W-1:0];
			OP_CHECK: begin
				if (stat.go_on) begin
					iter_q <= iter_q + 1'b1;
					diff_q <= '0;
				end
			end
			OP_CT_MUL: begin
				prod_q <= mult[DAMP_W+RANK_W-1:16];
				deg_q  <= row_deg;
			end
			OP_CT_WR: acc_q <= base_q;
			OP_AC_ADD: begin
				if (row_bits[i_q]) begin
					acc_q <= (sum[RANK_W+1:RANK_W] != 2'b00) ? '1 : sum[RANK_W-1:0];
				end
			end
			OP_AC_WR: begin
				acc_q  <= base_q;
				diff_q <= diff_q + DIFF_W'(absdiff);
				if (stat.i_last) begin
					bank_q <= ~bank_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
			j_q <= '0;
		end else begin
			if (cmd.i_clr) begin
				i_q <= '0;
			end else if (cmd.i_inc) begin
				i_q <= i_q + 1'b1;
			end
			if (cmd.j_clr) begin
				j_q <= '0;
			end else if (cmd.j_inc) begin
				j_q <= j_q + 1'b1;
			end
		end
	end

	assign stat.div_busy = div_busy;
	assign stat.i_last   = (i_q == n_last);
	assign stat.j_last   = (j_q == n_last);
	assign stat.go_on    = (iter_q < cfg.max_iter) && (diff_q >= DIFF_W'(cfg.thr));

	assign vertex_index   = i_q;
	assign rank_value     = rd_q;
	assign iterations_run = iter_q;
	assign last_result    = stat.i_last;

endmodule

// File: rtl/pagerank_power_iteration.sv
// channel   | transfer on                | contents
// ----------+----------------------------+------------------------------------------
// command   | start && !busy             | action, edge_source, edge_target
// result    | result_valid (one cycle)   | vertex_index, rank_value, iterations_run,
//           |                            | last_result
// config    | cfg_valid && cfg_ready     | cfg_index, cfg_data
// add edge loads the edge, reads the source row, then writes it back; clear and action 3 are handled in idle.
// compute: setup of two 33-step divides and an init pass over the N ranks, then per
// iteration the contributions (one divider shared by all vertices) and the sums
// (every adjacency row read in turn through an AC_RD and an AC_ADD state).
// the N results follow, each from an OUT_RD and an OUT state; the receiver cannot stall them.
// reset empties the graph at once through per-row valid flags, no clearing pass.
module pagerank_power_iteration
	import pgr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        action,
	input  logic [IDX_W-1:0]  edge_source,
	input  logic [IDX_W-1:0]  edge_target,
	output logic              result_valid,
	output logic [IDX_W-1:0]  vertex_index,
	output logic [RANK_W-1:0] rank_value,
	output logic [ITER_W-1:0] iterations_run,
	output logic              last_result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [31:0]       cfg_data
);

	logic [DAMP_W-1:0] damp_q;
	logic [THR_W-1:0]  thr_q;
	logic [ITER_W-1:0] max_iter_q;
	logic [CNT_W-1:0]  count_q;
	cfg_t              cfg;
	cmd_t              cmd;
	stat_t             stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			damp_q     <= 17'd55706;
			thr_q      <= 32'd10737;
			max_iter_q <= 16'd1000;
			count_q    <= 7'd64;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_DAMP:  damp_q     <= cfg_data[DAMP_W-1:0];
				REG_THR:   thr_q      <= cfg_data[THR_W-1:0];
				REG_ITER:  max_iter_q <= cfg_data[ITER_W-1:0];
				REG_COUNT: count_q    <= cfg_data[CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		cfg.damp     = (damp_q > DAMP_ONE) ? DAMP_ONE : damp_q;
		cfg.thr      = thr_q;
		cfg.max_iter = max_iter_q;
		if (count_q == '0) begin
			cfg.n = CNT_W'(1);
		end else if (count_q > N_MAX) begin
			cfg.n = N_MAX;
		end else begin
			cfg.n = count_q;
		end
	end

	pgr_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.action       (action),
		.stat         (stat),
		.cmd          (cmd),
		.busy         (busy),
		.result_valid (result_valid)
	);

	pgr_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.cfg            (cfg),
		.edge_source    (edge_source),
		.edge_target    (edge_target),
		.stat           (stat),
		.vertex_index   (vertex_index),
		.rank_value     (rank_value),
		.iterations_run (iterations_run),
		.last_result    (last_result)
	);

endmodule
